@@ hdl/csl_pkg.sv @@
`default_nettype none
package csl_pkg;
  localparam int MaxIdentLen = 32;
  localparam int LenW = $clog2(MaxIdentLen + 1);
  localparam int AddrW = $clog2(MaxIdentLen);

  localparam logic [2:0] KSep = 3'd0;
  localparam logic [2:0] KOp = 3'd1;
  localparam logic [2:0] KKw = 3'd2;
  localparam logic [2:0] KId = 3'd3;
  localparam logic [2:0] KInt = 3'd4;
  localparam logic [2:0] KEnd = 3'd5;
  localparam logic [2:0] KErr = 3'd6;

  localparam logic [5:0] ErrChar = 6'd0;
  localparam logic [5:0] ErrLong = 6'd1;
  localparam logic [5:0] OpShr = 6'd13;
  localparam logic [5:0] OpShl = 6'd12;
  localparam logic [5:0] OpShrEq = 6'd31;
  localparam logic [5:0] OpShlEq = 6'd32;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] code;
    logic [31:0] value;
    logic [7:0] ch;
    logic [4:0] idx;
    logic done;
    logic last;
  } tok_t;

  // Datapath commands from the controller.
  typedef struct packed {
    logic buf_wr;      // store byte at word length
    logic len_clr;
    logic num_load;    // load digit
    logic num_acc;     // acc*10+digit
    logic num_clr;
    logic rd_start;    // start reading buffer from 0
    logic rd_next;
  } csl_cmd_t;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [31:0] num;
    logic [7:0] rd_data;
    logic [AddrW-1:0] rd_idx;
    logic [2:0] kw_hit;  // keyword code, meaningful when kw_valid
    logic kw_valid;
  } csl_sts_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction
  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction
  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic logic starts_pair(input logic [7:0] c);
    return c == "+" || c == "-" || c == "<" || c == ">" || c == "=" || c == "!" ||
           c == "&" || c == "|" || c == "*" || c == "/" || c == "%" || c == "^";
  endfunction
  // {hit, kind, code}
  function automatic logic [9:0] one_lookup(input logic [7:0] c);
    logic [9:0] r;
    r = '0;
    unique case (c)
      "+": r = {1'b1, KOp, 6'd0};
      "-": r = {1'b1, KOp, 6'd1};
      "*": r = {1'b1, KOp, 6'd2};
      "%": r = {1'b1, KOp, 6'd3};
      "/": r = {1'b1, KOp, 6'd4};
      "~": r = {1'b1, KOp, 6'd7};
      "&": r = {1'b1, KOp, 6'd8};
      "|": r = {1'b1, KOp, 6'd9};
      "^": r = {1'b1, KOp, 6'd10};
      "=": r = {1'b1, KOp, 6'd11};
      "!": r = {1'b1, KOp, 6'd14};
      "<": r = {1'b1, KOp, 6'd19};
      ">": r = {1'b1, KOp, 6'd20};
      "(": r = {1'b1, KSep, 6'd0};
      ")": r = {1'b1, KSep, 6'd1};
      "{": r = {1'b1, KSep, 6'd2};
      "}": r = {1'b1, KSep, 6'd3};
      ",": r = {1'b1, KSep, 6'd4};
      ";": r = {1'b1, KSep, 6'd5};
      ":": r = {1'b1, KSep, 6'd6};
      "?": r = {1'b1, KSep, 6'd7};
      default: r = '0;
    endcase
    return r;
  endfunction
  // {hit, code}
  function automatic logic [6:0] pair_lookup(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    logic [6:0] r;
    p = {a, b};
    r = '0;
    unique case (p)
      "++": r = {1'b1, 6'd6};
      "--": r = {1'b1, 6'd5};
      "==": r = {1'b1, 6'd17};
      "!=": r = {1'b1, 6'd18};
      "<=": r = {1'b1, 6'd21};
      ">=": r = {1'b1, 6'd22};
      "&&": r = {1'b1, 6'd15};
      "||": r = {1'b1, 6'd16};
      "+=": r = {1'b1, 6'd23};
      "-=": r = {1'b1, 6'd24};
      "*=": r = {1'b1, 6'd25};
      "/=": r = {1'b1, 6'd26};
      "%=": r = {1'b1, 6'd27};
      "&=": r = {1'b1, 6'd28};
      "|=": r = {1'b1, 6'd29};
      "^=": r = {1'b1, 6'd30};
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ hdl/csl_datapath.sv @@
`default_nettype none
module csl_datapath (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [7:0] byte_i,
  input  wire csl_pkg::csl_cmd_t cmd_i,
  output csl_pkg::csl_sts_t sts_o
);
  import csl_pkg::*;

  logic [7:0] mem [MaxIdentLen];
  logic [LenW-1:0] len_q;
  logic [31:0] num_q;
  logic [AddrW-1:0] rd_idx_q;
  logic [AddrW-1:0] rd_addr;
  logic [7:0] rd_data_q;
  logic [47:0] kw_q;  // first six buffered chars, keyword check
  logic [31:0] times_ten;

  assign times_ten = (num_q << 3) + (num_q << 1);

  // Read address follows the index it will hold next cycle.
  always_comb begin
    if (cmd_i.rd_start) begin
      rd_addr = '0;
    end else if (cmd_i.rd_next) begin
      rd_addr = rd_idx_q + AddrW'(1);
    end else begin
      rd_addr = rd_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_wr && len_q < LenW'(MaxIdentLen)) begin
      mem[len_q[AddrW-1:0]] <= byte_i;
    end
    rd_data_q <= mem[rd_addr];
    if (cmd_i.buf_wr && len_q < LenW'(6)) begin
      kw_q[len_q[2:0]*8 +: 8] <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      num_q <= '0;
      rd_idx_q <= '0;
    end else begin
      if (cmd_i.len_clr) begin
        len_q <= '0;
      end else if (cmd_i.buf_wr) begin
        len_q <= len_q + LenW'(1);
      end
      if (cmd_i.num_clr) begin
        num_q <= '0;
      end else if (cmd_i.num_load) begin
        num_q <= {28'd0, byte_i[3:0]};
      end else if (cmd_i.num_acc) begin
        num_q <= times_ten + {28'd0, byte_i[3:0]};
      end
      if (cmd_i.rd_start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.rd_next) begin
        rd_idx_q <= rd_idx_q + AddrW'(1);
      end
    end
  end

  always_comb begin
    sts_o.len = len_q;
    sts_o.num = num_q;
    sts_o.rd_data = rd_data_q;
    sts_o.rd_idx = rd_idx_q;
    sts_o.kw_valid = 1'b1;
    sts_o.kw_hit = 3'd0;
    if (len_q == LenW'(2) && kw_q[15:0] == "fi") sts_o.kw_hit = 3'd0;
    else if (len_q == LenW'(4) && kw_q[31:0] == "esle") sts_o.kw_hit = 3'd1;
    else if (len_q == LenW'(3) && kw_q[23:0] == "tni") sts_o.kw_hit = 3'd2;
    else if (len_q == LenW'(6) && kw_q[47:0] == "nruter") sts_o.kw_hit = 3'd3;
    else if (len_q == LenW'(4) && kw_q[31:0] == "diov") sts_o.kw_hit = 3'd4;
    else sts_o.kw_valid = 1'b0;
  end
endmodule
`default_nettype wire

@@ hdl/csl_ctrl.sv @@
`default_nettype none
module csl_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic [7:0] byte_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output csl_pkg::tok_t tok_o,
  output csl_pkg::csl_cmd_t cmd_o,
  input  wire csl_pkg::csl_sts_t sts_i
);
  import csl_pkg::*;

  typedef enum logic [2:0] {
    MIdle, MIdent, MNumber, MPunct, MError
  } mode_e;
  typedef enum logic [1:0] {
    SRun, SDump, SRest
  } st_e;

  // Up to two results can follow one byte outside a dump: hold them in slots.
  mode_e mode_q, mode_d;
  st_e st_q, st_d;
  logic [7:0] p0_q, p0_d;
  logic p2_q, p2_d;
  logic [7:0] c_q, c_d;      // byte that ended an identifier
  tok_t q_q [2];
  tok_t q_d [2];
  logic [1:0] qn_q, qn_d;
  tok_t o_q, o_d;
  logic ov_q, ov_d;
  logic [LenW-1:0] dlen_q, dlen_d;

  tok_t r [3];
  logic [1:0] rn;
  logic ident_flush;
  logic acc;
  logic free;
  logic dump_end;
  logic rest_hit;
  tok_t rest_t;
  logic [9:0] one_c, one_p, one_r;
  logic [6:0] pr;

  function automatic tok_t mk(input logic [2:0] k, input logic [5:0] cd);
    tok_t t;
    t = '0;
    t.kind = k;
    t.code = cd;
    t.done = 1'b1;
    return t;
  endfunction

  assign free = !(ov_q && !out_ready_i);
  assign acc = in_valid_i && in_ready_o;
  assign one_c = one_lookup(byte_i);
  assign one_p = one_lookup(p0_q);
  assign one_r = one_lookup(c_q);
  assign pr = pair_lookup(p0_q, byte_i);
  assign dump_end = LenW'(sts_i.rd_idx) + LenW'(1) == dlen_q;

  // Result of the byte that ended a dumped identifier, handled as from idle.
  always_comb begin
    rest_hit = !(is_space(c_q) || starts_pair(c_q));
    if (c_q == 8'd0) begin
      rest_t = mk(KEnd, 6'd0);
    end else if (one_r[9]) begin
      rest_t = mk(one_r[8:6], one_r[5:0]);
    end else begin
      rest_t = mk(KErr, ErrChar);
    end
    rest_t.last = 1'b1;
  end

  // Byte handling, commands and output sequencing.
  always_comb begin
    mode_d = mode_q;
    st_d = st_q;
    p0_d = p0_q;
    p2_d = p2_q;
    c_d = c_q;
    dlen_d = dlen_q;
    o_d = o_q;
    ov_d = !free;
    q_d = q_q;
    qn_d = qn_q;
    rn = 2'd0;
    ident_flush = 1'b0;
    cmd_o = '0;
    for (int i = 0; i < 3; i++) r[i] = '0;
    if (acc) begin
      logic go_idle;
      go_idle = 1'b0;
      unique case (mode_q)
        MError: if (byte_i == 8'd0) go_idle = 1'b1;
        MIdent: begin
          if (is_alpha(byte_i) || is_digit(byte_i)) begin
            if (sts_i.len >= LenW'(MaxIdentLen)) begin
              r[0] = mk(KErr, ErrLong);
              rn = 2'd1;
              cmd_o.len_clr = 1'b1;
              mode_d = MError;
            end else begin
              cmd_o.buf_wr = 1'b1;
            end
          end else if (sts_i.kw_valid) begin
            r[0] = mk(KKw, {3'd0, sts_i.kw_hit});
            rn = 2'd1;
            cmd_o.len_clr = 1'b1;
            go_idle = 1'b1;
          end else begin
            ident_flush = 1'b1;
            cmd_o.rd_start = 1'b1;
          end
        end
        MNumber: begin
          if (is_digit(byte_i)) cmd_o.num_acc = 1'b1;
          else begin
            r[0] = mk(KInt, 6'd0);
            r[0].value = sts_i.num;
            rn = 2'd1;
            cmd_o.num_clr = 1'b1;
            go_idle = 1'b1;
          end
        end
        MPunct: begin
          if (p2_q) begin
            p2_d = 1'b0;
            if (byte_i == "=") begin
              r[0] = mk(KOp, p0_q == ">" ? OpShrEq : OpShlEq);
              rn = 2'd1;
              mode_d = MIdle;
            end else begin
              r[0] = mk(KOp, p0_q == ">" ? OpShr : OpShl);
              rn = 2'd1;
              go_idle = 1'b1;
            end
          end else if ((p0_q == "<" || p0_q == ">") && byte_i == p0_q) begin
            p2_d = 1'b1;
          end else if (pr[6]) begin
            r[0] = mk(KOp, pr[5:0]);
            rn = 2'd1;
            mode_d = MIdle;
          end else begin
            if (one_p[9]) begin
              r[0] = mk(one_p[8:6], one_p[5:0]);
              rn = 2'd1;
            end
            go_idle = 1'b1;
          end
        end
        default: go_idle = 1'b1;
      endcase
      if (go_idle) begin
        mode_d = MIdle;
        if (byte_i == 8'd0) begin
          r[rn] = mk(KEnd, 6'd0);
          rn = rn + 2'd1;
          cmd_o.len_clr = 1'b1;
          cmd_o.num_clr = 1'b1;
        end else if (is_space(byte_i)) begin
        end else if (is_alpha(byte_i)) begin
          cmd_o.buf_wr = 1'b1;
          mode_d = MIdent;
        end else if (is_digit(byte_i)) begin
          cmd_o.num_load = 1'b1;
          cmd_o.num_clr = 1'b0;
          mode_d = MNumber;
        end else if (starts_pair(byte_i)) begin
          p0_d = byte_i;
          mode_d = MPunct;
        end else if (one_c[9]) begin
          r[rn] = mk(one_c[8:6], one_c[5:0]);
          rn = rn + 2'd1;
        end else begin
          r[rn] = mk(KErr, ErrChar);
          rn = rn + 2'd1;
          mode_d = MError;
        end
      end
    end
    unique case (st_q)
      SRun: begin
        if (acc && ident_flush) begin
          st_d = SDump;
          dlen_d = sts_i.len;
          c_d = byte_i;
          mode_d = MIdle;
        end else if (acc && rn != 2'd0) begin
          o_d = r[0];
          o_d.last = rn == 2'd1;
          ov_d = 1'b1;
          q_d[0] = r[1];
          q_d[0].last = rn == 2'd2;
          q_d[1] = r[2];
          q_d[1].last = 1'b1;
          qn_d = rn - 2'd1;
        end else if (free && qn_q != 2'd0) begin
          o_d = q_q[0];
          ov_d = 1'b1;
          q_d[0] = q_q[1];
          qn_d = qn_q - 2'd1;
        end
      end
      SDump: begin
        // advance one character per free output slot
        if (free) begin
          cmd_o.rd_next = 1'b1;
          o_d = '0;
          o_d.kind = KId;
          o_d.ch = sts_i.rd_data;
          o_d.idx = 5'(sts_i.rd_idx);
          o_d.done = dump_end;
          o_d.last = dump_end && !rest_hit;
          ov_d = 1'b1;
          if (dump_end) st_d = SRest;
        end
      end
      default: begin
        // replay the ending byte in idle mode
        if (free) begin
          cmd_o.len_clr = 1'b1;
          st_d = SRun;
          if (rest_hit) begin
            o_d = rest_t;
            ov_d = 1'b1;
          end
          if (starts_pair(c_q)) begin
            p0_d = c_q;
            mode_d = MPunct;
          end else if (rest_hit && rest_t.kind == KErr) begin
            mode_d = MError;
          end
        end
      end
    endcase
  end

  // Ready only when output slots are free and not dumping.
  assign in_ready_o = st_q == SRun && qn_q == 2'd0 && free;
  assign out_valid_o = ov_q;
  assign tok_o = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle;
      st_q <= SRun;
      p0_q <= '0;
      p2_q <= 1'b0;
      c_q <= '0;
      q_q[0] <= '0;
      q_q[1] <= '0;
      qn_q <= '0;
      o_q <= '0;
      ov_q <= 1'b0;
      dlen_q <= '0;
    end else begin
      mode_q <= mode_d;
      st_q <= st_d;
      p0_q <= p0_d;
      p2_q <= p2_d;
      c_q <= c_d;
      q_q[0] <= q_d[0];
      q_q[1] <= q_d[1];
      qn_q <= qn_d;
      o_q <= o_d;
      ov_q <= ov_d;
      dlen_q <= dlen_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> qn_q == 2'd0)
    else $error("accepting with queued results");
  assert property (@(posedge clk_i) disable iff (!rst_ni) st_q == SDump |-> !in_ready_o)
    else $error("accept during dump");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> ov_q && $stable(o_q))
    else $error("output lost");
endmodule
`default_nettype wire

@@ hdl/c_subset_lexer.sv @@
`default_nettype none
// Output: a byte's first result item is valid in the cycle after acceptance;
// characters of a plain identifier it ends pass the buffer read register first.
// Throughput: one byte per cycle; two result items hold input until the second
// leaves its slot, an identifier flush holds it until its word is read back and
// its end byte replayed, and output backpressure while the output item waits.
// Reset: rst_ni asynchronous active low; clears mode, counts and output valid.
module c_subset_lexer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // source_byte
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // token_kind[2:0] token_code[8:3] int_value[40:9] ident_char[48:41]
  // ident_index[53:49] token_done[54]
  output logic [55:0] m_axis_tdata,
  output logic m_axis_tlast
);
  import csl_pkg::*;

  csl_cmd_t cmd;
  csl_sts_t sts;
  tok_t tok;

  csl_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .byte_i(s_axis_tdata), .cmd_i(cmd), .sts_o(sts)
  );
  csl_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .byte_i(s_axis_tdata),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .tok_o(tok),
    .cmd_o(cmd), .sts_i(sts)
  );

  // Pack fields, lowest first.
  assign m_axis_tdata = {1'b0, tok.done, tok.idx, tok.ch, tok.value, tok.code, tok.kind};
  assign m_axis_tlast = tok.last;
endmodule
`default_nettype wire

@@ test/c_subset_lexer_tb.sv @@
`default_nettype none
module c_subset_lexer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csl_pkg::*;

  // Byte-stream check of the lexer: a short table of hand-picked source bytes,
  // then random C-like text (keywords, names, numbers, operators, whitespace,
  // stray bytes, end markers) checked against a predictor kept in this module.

  localparam int CycleLimit = 600000;
  localparam int RandomBytes = 460;
  localparam int LongHold = 400;

  typedef enum logic [2:0] {LxIdle, LxWord, LxNum, LxPunct, LxSkip} lex_state_e;

  // one directed row: a source byte, plus a typed result where obvious
  typedef struct {
    logic [7:0] src;
    bit         typed;
    logic [2:0] kind;
    logic [5:0] code;
  } drow_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  c_subset_lexer uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  lex_state_e lx_state;
  logic [7:0] word_chars [MaxIdentLen];
  int         word_len;
  logic [31:0] num_acc;
  logic [7:0] punct_first;
  int         punct_count;

  tok_t step_toks[$];    // results of the byte being predicted
  tok_t token_fifo[$];   // results still owed by the block

  logic [7:0] src_bytes[$];
  bit         src_typed[$];
  tok_t       src_tok[$];

  int errors = 0;
  int sent = 0;
  int tokens_seen = 0;
  int ends_seen = 0;
  int cycles = 0;

  string kw_names[5] = '{"if", "else", "int", "return", "void"};
  string ops_text[41] = '{"+", "-", "*", "%", "/", "--", "++", "~", "&", "|", "^", "=",
    "<<", ">>", "!", "&&", "||", "==", "!=", "<", ">", "<=", ">=", "+=", "-=", "*=",
    "/=", "%=", "&=", "|=", "^=", ">>=", "<<=", "(", ")", "{", "}", ",", ";", ":", "?"};
  string alpha_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string alnum_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  function automatic bit name_start(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction
  function automatic bit dec_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic bit opens_pair(logic [7:0] c);
    case (c)
      "+", "-", "<", ">", "=", "!", "&", "|", "*", "/", "%", "^": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction
  function automatic int pair_code(logic [7:0] a, logic [7:0] b);
    case ({a, b})
      "++": return 6;   "--": return 5;   "<<": return OpShl; ">>": return OpShr;
      "==": return 17;  "!=": return 18;  "<=": return 21;    ">=": return 22;
      "&&": return 15;  "||": return 16;  "+=": return 23;    "-=": return 24;
      "*=": return 25;  "/=": return 26;  "%=": return 27;    "&=": return 28;
      "|=": return 29;  "^=": return 30;
      default: return -1;
    endcase
  endfunction

  task automatic push_tok(logic [2:0] kind, logic [5:0] code, logic [31:0] value,
                          logic [7:0] ch, logic [4:0] idx, logic done);
    tok_t t;
    t = '{kind: kind, code: code, value: value, ch: ch, idx: idx, done: done, last: 1'b0};
    step_toks.push_back(t);
  endtask

  // emit a one-character operator or separator; other bytes give nothing
  task automatic push_single(logic [7:0] c);
    case (c)
      "+": push_tok(KOp, 0, 0, 0, 0, 1);  "-": push_tok(KOp, 1, 0, 0, 0, 1);
      "*": push_tok(KOp, 2, 0, 0, 0, 1);  "%": push_tok(KOp, 3, 0, 0, 0, 1);
      "/": push_tok(KOp, 4, 0, 0, 0, 1);  "~": push_tok(KOp, 7, 0, 0, 0, 1);
      "&": push_tok(KOp, 8, 0, 0, 0, 1);  "|": push_tok(KOp, 9, 0, 0, 0, 1);
      "^": push_tok(KOp, 10, 0, 0, 0, 1); "=": push_tok(KOp, 11, 0, 0, 0, 1);
      "!": push_tok(KOp, 14, 0, 0, 0, 1); "<": push_tok(KOp, 19, 0, 0, 0, 1);
      ">": push_tok(KOp, 20, 0, 0, 0, 1);
      "(": push_tok(KSep, 0, 0, 0, 0, 1); ")": push_tok(KSep, 1, 0, 0, 0, 1);
      "{": push_tok(KSep, 2, 0, 0, 0, 1); "}": push_tok(KSep, 3, 0, 0, 0, 1);
      ",": push_tok(KSep, 4, 0, 0, 0, 1); ";": push_tok(KSep, 5, 0, 0, 0, 1);
      ":": push_tok(KSep, 6, 0, 0, 0, 1); "?": push_tok(KSep, 7, 0, 0, 0, 1);
      default: ;
    endcase
  endtask

  function automatic bit single_char(logic [7:0] c);
    case (c)
      "+", "-", "*", "%", "/", "~", "&", "|", "^", "=", "!", "<", ">",
      "(", ")", "{", "}", ",", ";", ":", "?": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // a finished word is a keyword or a run of character items
  task automatic flush_word();
    bit same;
    for (int k = 0; k < 5; k++) begin
      if (kw_names[k].len() != word_len) continue;
      same = 1'b1;
      for (int j = 0; j < word_len; j++)
        if (word_chars[j] != kw_names[k][j]) same = 1'b0;
      if (same) begin
        push_tok(KKw, 6'(k), 0, 0, 0, 1);
        return;
      end
    end
    for (int j = 0; j < word_len; j++)
      push_tok(KId, 0, 0, word_chars[j], j[4:0], j + 1 == word_len);
  endtask

  task automatic start_token(logic [7:0] c);
    lx_state = LxIdle;
    if (c == 8'd0) begin
      push_tok(KEnd, 0, 0, 0, 0, 1);
      word_len = 0;
      num_acc = '0;
      punct_count = 0;
    end else if (blank(c)) begin
    end else if (name_start(c)) begin
      word_chars[0] = c;
      word_len = 1;
      lx_state = LxWord;
    end else if (dec_digit(c)) begin
      num_acc = 32'(c - "0");
      lx_state = LxNum;
    end else if (opens_pair(c)) begin
      punct_first = c;
      punct_count = 1;
      lx_state = LxPunct;
    end else if (single_char(c)) begin
      push_single(c);
    end else begin
      push_tok(KErr, ErrChar, 0, 0, 0, 1);
      lx_state = LxSkip;
    end
  endtask

  // advance the predictor by one byte and queue what it owes
  task automatic predict_byte(logic [7:0] c);
    int pc;
    step_toks.delete();
    case (lx_state)
      LxSkip: if (c == 8'd0) start_token(c);
      LxWord: begin
        if (name_start(c) || dec_digit(c)) begin
          if (word_len >= MaxIdentLen) begin
            push_tok(KErr, ErrLong, 0, 0, 0, 1);
            word_len = 0;
            lx_state = LxSkip;
          end else begin
            word_chars[word_len] = c;
            word_len++;
          end
        end else begin
          flush_word();
          word_len = 0;
          start_token(c);
        end
      end
      LxNum: begin
        if (dec_digit(c)) begin
          num_acc = num_acc * 32'd10 + 32'(c - "0");
        end else begin
          push_tok(KInt, 0, num_acc, 0, 0, 1);
          num_acc = '0;
          start_token(c);
        end
      end
      LxPunct: begin
        if (punct_count >= 2) begin
          punct_count = 0;
          if (c == "=") begin
            push_tok(KOp, punct_first == ">" ? OpShrEq : OpShlEq, 0, 0, 0, 1);
            lx_state = LxIdle;
          end else begin
            push_tok(KOp, punct_first == ">" ? OpShr : OpShl, 0, 0, 0, 1);
            start_token(c);
          end
        end else if ((punct_first == "<" || punct_first == ">") && c == punct_first) begin
          punct_count = 2;
        end else begin
          pc = pair_code(punct_first, c);
          punct_count = 0;
          if (pc >= 0) begin
            push_tok(KOp, pc[5:0], 0, 0, 0, 1);
            lx_state = LxIdle;
          end else begin
            push_single(punct_first);
            start_token(c);
          end
        end
      end
      default: start_token(c);
    endcase
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
  endtask

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at item %0d: %s got 0x%0h want 0x%0h", tokens_seen, field, got, want);
  endtask

  task automatic add_bytes(string s);
    for (int i = 0; i < s.len(); i++) begin
      src_bytes.push_back(s[i]);
      src_typed.push_back(1'b0);
      src_tok.push_back('0);
    end
  endtask

  task automatic add_byte(logic [7:0] b);
    src_bytes.push_back(b);
    src_typed.push_back(1'b0);
    src_tok.push_back('0);
  endtask

  task automatic build_stimulus();
    drow_t rows[$];
    int r, n;
    // end byte right after reset, a high stray byte, keyword, a wrapping
    // number, >>= and << then a letter, a name cut by a control byte
    rows = '{
      '{8'd0, 1, KEnd, 0}, '{8'hff, 1, KErr, ErrChar}, '{8'd0, 1, KEnd, 0},
      '{"i", 0, 0, 0}, '{"f", 0, 0, 0}, '{" ", 0, 0, 0},
      '{"9", 0, 0, 0}, '{"9", 0, 0, 0}, '{"9", 0, 0, 0}, '{"9", 0, 0, 0},
      '{"9", 0, 0, 0}, '{"9", 0, 0, 0}, '{"9", 0, 0, 0}, '{"9", 0, 0, 0},
      '{"9", 0, 0, 0}, '{"9", 0, 0, 0},
      '{">", 0, 0, 0}, '{">", 0, 0, 0}, '{"=", 1, KOp, OpShrEq},
      '{"<", 0, 0, 0}, '{"<", 0, 0, 0}, '{"_", 1, KOp, OpShl},
      '{8'h01, 0, 0, 0}, '{8'd0, 1, KEnd, 0}};
    foreach (rows[i]) begin
      src_bytes.push_back(rows[i].src);
      src_typed.push_back(rows[i].typed);
      src_tok.push_back('{kind: rows[i].kind, code: rows[i].code, value: 0, ch: 0,
                          idx: 0, done: 1'b1, last: 1'b1});
    end
    // random C-like text: mostly well-formed tokens, some noise and ends
    while (src_bytes.size() < rows.size() + RandomBytes) begin
      r = $urandom_range(0, 99);
      if (r < 7) begin
        add_byte(8'd0);
      end else if (r < 12) begin
        add_byte(8'($urandom_range(1, 255)));
      end else if (r < 20) begin
        add_byte($urandom_range(0, 5) == 0 ? 8'd32 : 8'($urandom_range(9, 13)));
      end else if (r < 32) begin
        add_bytes(kw_names[$urandom_range(0, 4)]);
        if ($urandom_range(0, 1)) add_byte(" ");
      end else if (r < 55) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
        add_byte(alpha_set[$urandom_range(0, alpha_set.len() - 1)]);
        for (int i = 1; i < n; i++)
          add_byte(alnum_set[$urandom_range(0, alnum_set.len() - 1)]);
      end else if (r < 72) begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) add_byte(8'("0" + $urandom_range(0, 9)));
      end else begin
        add_bytes(ops_text[$urandom_range(0, 40)]);
      end
    end
    add_byte(8'd0);
  endtask

  // sender: bursts of random length with random gaps
  initial begin
    int burst, gap;
    build_stimulus();
    burst = 1;
    gap = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (sent < src_bytes.size()) begin
      @(posedge clk_i);
      if (s_axis_tvalid && s_axis_tready) begin
        predict_byte(src_bytes[sent]);
        // directed rows with a typed answer replace the predicted one
        if (src_typed[sent]) token_fifo.push_back(src_tok[sent]);
        else foreach (step_toks[i]) token_fifo.push_back(step_toks[i]);
        sent++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered item
      end else if (gap > 0) begin
        gap--;
        s_axis_tvalid <= 1'b0;
      end else if (sent < src_bytes.size()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= src_bytes[sent];
        burst--;
        if (burst <= 0) begin
          burst = $urandom_range(1, 40);
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern of its own, one long hold-off, and the checker
  initial begin
    int hold, stall_pct, phase;
    bit held;
    tok_t want, got;
    hold = 0;
    held = 1'b0;
    stall_pct = 0;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{kind: m_axis_tdata[2:0], code: m_axis_tdata[8:3],
                value: m_axis_tdata[40:9], ch: m_axis_tdata[48:41],
                idx: m_axis_tdata[53:49], done: m_axis_tdata[54], last: m_axis_tlast};
        if (token_fifo.size() == 0) begin
          report("unexpected item kind", 32'(got.kind), 32'd0);
        end else begin
          want = token_fifo.pop_front();
          if (got.kind != want.kind) report("kind", 32'(got.kind), 32'(want.kind));
          if (got.code != want.code) report("code", 32'(got.code), 32'(want.code));
          if (got.value != want.value) report("value", got.value, want.value);
          if (got.ch != want.ch) report("char", 32'(got.ch), 32'(want.ch));
          if (got.idx != want.idx) report("index", 32'(got.idx), 32'(want.idx));
          if (got.done != want.done) report("done", 32'(got.done), 32'(want.done));
          if (got.last != want.last) report("last", 32'(got.last), 32'(want.last));
          if (want.kind == KEnd) ends_seen++;
        end
        tokens_seen++;
      end
      phase++;
      if (phase % 128 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (!held && sent >= 150) begin
        // long hold-off: let the block fill up and stall its input
        held = 1'b1;
        hold = LongHold;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    wait (rst_ni);
    wait (sent == src_bytes.size() && src_bytes.size() > 0);
    wait (token_fifo.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("ran %0d source bytes through the lexer, %0d result items, %0d end markers",
             sent, tokens_seen, ends_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ c_subset_lexer.f @@
hdl/csl_pkg.sv
hdl/csl_datapath.sv
hdl/csl_ctrl.sv
hdl/c_subset_lexer.sv
test/c_subset_lexer_tb.sv
